[hdl/indexed_list_insert_delete_core_assert.svh]
// Assertion macros used by the indexed list core RTL.
// Needs clk and rst_n in scope at the point of use.
`ifndef INDEXED_LIST_INSERT_DELETE_CORE_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_CORE_ASSERT_SVH

// same-cycle implication, reset masks the check
`define ILID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define ILID_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ilid_pkg.sv]
// Package for the indexed list core: sizes, mode and status codes, cell ops.
// No dependencies.
package ilid_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int MODE_W   = 3;
  localparam int INIDX_W  = 6;
  localparam int POS_W    = 6;
  localparam int STAT_W   = 2;
  localparam int OCNT_W   = 7;
  localparam int CMP_W    = 7;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [IDX_W-1:0]         idx_t;

  localparam logic [MODE_W-1:0] MODE_FRONT    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BACK     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TRAVERSE = 3'd4;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_TRAV
  } state_t;

endpackage

[hdl/indexed_list_insert_delete_core.sv]
// Indexed list core: a chain of cells shifting right on insert, left on pop.
// A status result is registered in the cycle after its transaction is accepted;
// inserts and pops sustain one transaction per cycle while the output is taken.
// Traverse of N entries: read out by a pointer over the cells, one per cycle while the
// output is taken; input is held off until the last entry is registered.
// Reset (rst_n low, synchronous): count cleared, output empty; cell contents undefined.
module indexed_list_insert_delete_core
  import ilid_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [5:0] index, [37:6] value, zero fill
  input  logic [2:0]  in_tuser,   // [2:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] elem_value, [37:32] elem_position,
                                  // [44:38] count, zero fill
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);

`include "indexed_list_insert_delete_core_assert.svh"

  state_t state_r, state_nxt;
  cnt_t   cnt_r, cnt_nxt;
  idx_t   ptr_r, ptr_nxt;

  logic              out_valid_r, out_valid_nxt;
  data_t             out_value_r, out_value_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic              out_last_r, out_last_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic [OCNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic [MODE_W-1:0]  in_mode;
  logic [INIDX_W-1:0] in_index;
  data_t              in_value;

  logic in_acc, out_free, full, is_ins, ins_ok, pop_ok, trav_last;
  logic [CMP_W-1:0] idx_cmp, cnt_cmp;
  idx_t ins_pos, pop_pos;

  cell_op_t cell_ops [CAPACITY];
  data_t    cell_q   [CAPACITY];

  assign in_mode  = in_tuser;
  assign in_index = in_tdata[INIDX_W-1:0];
  assign in_value = data_t'(in_tdata[INIDX_W+DATA_W-1:INIDX_W]);

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  assign idx_cmp = CMP_W'(in_index);
  assign cnt_cmp = CMP_W'(cnt_r);
  assign full    = (cnt_r == CNT_W'(CAPACITY));
  assign is_ins  = (in_mode == MODE_FRONT) || (in_mode == MODE_BACK) ||
                   (in_mode == MODE_INSERT);
  assign ins_ok  = in_acc && is_ins && !full;
  assign pop_ok  = in_acc && (in_mode == MODE_POP) && (idx_cmp < cnt_cmp);
  assign pop_pos = IDX_W'(in_index);

  always_comb begin
    case (in_mode)
      MODE_FRONT: ins_pos = '0;
      MODE_BACK:  ins_pos = IDX_W'(cnt_r);
      default:    ins_pos = (idx_cmp >= cnt_cmp) ? IDX_W'(cnt_r) : IDX_W'(in_index);
    endcase
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ops[i] = CELL_HOLD;
      if (ins_ok) begin
        if (IDX_W'(i) == ins_pos)     cell_ops[i] = CELL_LOAD;
        else if (IDX_W'(i) > ins_pos) cell_ops[i] = CELL_FROM_LEFT;
      end else if (pop_ok) begin
        if (IDX_W'(i) >= pop_pos)     cell_ops[i] = CELL_FROM_RIGHT;
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ilid_cell u_cell (
      .clk      (clk),
      .cell_op  (cell_ops[g]),
      .left_q   ((g == 0) ? cell_q[0] : cell_q[(g == 0) ? 0 : g - 1]),
      .right_q  (cell_q[(g == CAPACITY - 1) ? g : g + 1]),
      .load_val (in_value),
      .q        (cell_q[g])
    );
  end

  assign trav_last = ((CNT_W'(ptr_r) + CNT_W'(1)) == cnt_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_value_nxt = out_value_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    out_stat_nxt  = out_stat_r;
    out_cnt_nxt   = out_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (ins_ok)      cnt_nxt = cnt_r + CNT_W'(1);
          else if (pop_ok) cnt_nxt = cnt_r - CNT_W'(1);
          if ((in_mode == MODE_TRAVERSE) && (cnt_r != '0)) begin
            state_nxt = ST_TRAV;
            ptr_nxt   = '0;
          end else begin
            out_valid_nxt = 1'b1;
            out_value_nxt = '0;
            out_pos_nxt   = '0;
            out_last_nxt  = 1'b1;
            out_cnt_nxt   = OCNT_W'(cnt_nxt);
            if (is_ins && full)                 out_stat_nxt = STAT_FULL;
            else if (in_mode == MODE_POP && !pop_ok) out_stat_nxt = STAT_RANGE;
            else if (in_mode == MODE_TRAVERSE)  out_stat_nxt = STAT_EMPTY;
            else                                out_stat_nxt = STAT_DONE;
          end
        end
      end
      ST_TRAV: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = cell_q[ptr_r];
          out_pos_nxt   = POS_W'(ptr_r);
          out_last_nxt  = trav_last;
          out_stat_nxt  = STAT_DONE;
          out_cnt_nxt   = OCNT_W'(cnt_r);
          ptr_nxt       = ptr_r + IDX_W'(1);
          if (trav_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_pos_r   <= out_pos_nxt;
    out_last_r  <= out_last_nxt;
    out_stat_r  <= out_stat_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_cnt_r, out_pos_r, out_value_r};
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

  `ILID_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `ILID_ASSERT_IMP(a_trav_blocks, state_r == ST_TRAV, !in_tready, "input taken during traverse")
  `ILID_ASSERT_NXT(a_trav_cnt, state_r == ST_TRAV, cnt_r == $past(cnt_r), "count moved in traverse")
  `ILID_ASSERT_NXT(a_ins_grows, ins_ok, cnt_r == $past(cnt_r) + CNT_W'(1), "insert did not grow list")

endmodule

[hdl/ilid_cell.sv]
// One storage cell of the list chain: holds, loads, or takes a neighbour's value.
// Depends on ilid_pkg.
module ilid_cell
  import ilid_pkg::*;
(
  input  logic     clk,
  input  cell_op_t cell_op,
  input  data_t    left_q,
  input  data_t    right_q,
  input  data_t    load_val,
  output data_t    q
);

  data_t q_r;
  data_t q_nxt;

  always_comb begin
    case (cell_op)
      CELL_HOLD:       q_nxt = q_r;
      CELL_LOAD:       q_nxt = load_val;
      CELL_FROM_LEFT:  q_nxt = left_q;
      CELL_FROM_RIGHT: q_nxt = right_q;
      default:         q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule
